// ===== sv/scba_pkg.sv =====
// Shared types and constants of the size-class bump allocator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package scba_pkg;

  localparam int NBINS      = 64;
  localparam int BIN_AW     = 6;
  localparam int HW         = 21;  // handle width
  localparam int OFW        = 17;  // offset width inside a free walk
  localparam int SZW        = 11;  // size field width
  localparam int CMDW       = 2;
  localparam int STW        = 2;
  localparam int MLW        = 6;   // min_leftover width
  localparam int MIN_LO_RST = 8;

  // floor(x/3) = (x * 43691) >> 17 for x below 2^16
  localparam int DIV3_MUL   = 43691;
  localparam int DIV3_SHIFT = 17;

  typedef enum logic [CMDW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHUNK = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  // single-port request to the bin head memory
  typedef struct packed {
    logic              en;
    logic              we;
    logic              clr;
    logic [BIN_AW-1:0] addr;
    logic [HW-1:0]     wdata;
  } bin_req_t;

endpackage

// ===== sv/scba_req_if.sv =====
// Request channel of the allocator: command, size and handle.
// Depends on scba_pkg for the field widths.
`timescale 1ns / 1ps

interface scba_req_if;
  logic                     valid;
  logic                     ready;
  logic [scba_pkg::CMDW-1:0] command;
  logic [scba_pkg::SZW-1:0]  size;
  logic [scba_pkg::HW-1:0]   block_handle;

  modport source (output valid, command, size, block_handle, input ready);
  modport sink   (input valid, command, size, block_handle, output ready);
endinterface

// ===== sv/scba_rsp_if.sv =====
// Result channel of the allocator: granted handle, status and bin flag.
// Depends on scba_pkg for the field widths.
`timescale 1ns / 1ps

interface scba_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [scba_pkg::HW-1:0]  granted_handle;
  logic [scba_pkg::STW-1:0] status;
  logic                     from_bin;

  modport source (output valid, granted_handle, status, from_bin, input ready);
  modport sink   (input valid, granted_handle, status, from_bin, output ready);
endinterface

// ===== sv/scba_bin_mem.sv =====
// Bin head memory: 64 list heads, single port, registered read.
// Depends on scba_pkg; per-entry valid bits make an empty bin read as 0.
`timescale 1ns / 1ps

module scba_bin_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scba_pkg::bin_req_t     req_i,
  output logic [scba_pkg::HW-1:0] rdata_o
);
  import scba_pkg::*;

  logic [HW-1:0]    mem [NBINS];
  logic [NBINS-1:0] vld_q;
  logic [HW-1:0]    rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.en && req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.en && !req_i.we) begin
        rvld_q <= vld_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== sv/scba_link_mem.sv =====
// Link store: one link word per byte address of the managed memory.
// Single port RAM with registered read; no dependencies.
`timescale 1ns / 1ps

module scba_link_mem #(
  parameter int              AW    = 14,
  parameter longint unsigned DEPTH = 16384,
  parameter int              DW    = 21
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/size_class_bump_allocator_unit.sv =====
// Size-class allocator with bump pointer: control sequencer and split walk.
// Depends on scba_pkg, scba_req_if, scba_rsp_if, scba_bin_mem, scba_link_mem.
`timescale 1ns / 1ps

// One item at a time. An allocate popped from a bin runs from acceptance
// through bin head read, link read and write-back to the result; a bump
// allocate runs from acceptance through the tail step to the result, reads
// the empty bin first when its size is below 64, adds a tail step when a new
// chunk opens, and adds the free walk of the leftover and an open step when
// one is given back. A free walks its pieces depth first: a step per split, a
// bin head read and then a bin and link write per piece pushed into a bin, a
// check per dropped piece, a stack pop step after each piece, and acceptance
// and the result. Clear and the unused command go from acceptance straight to
// the result. A result waiting in the output register does not hold off the
// next item. No clearing pass: bins empty on reset and clear at once.
module size_class_bump_allocator_unit #(
  parameter int CHUNK_BYTES = 1024,
  parameter int NUM_CHUNKS  = 16,
  parameter int SPLIT_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [scba_pkg::MLW-1:0] cfg_wdata_i,
  scba_req_if.sink                 req_i,
  scba_rsp_if.source               rsp_o
);
  import scba_pkg::*;

  localparam int NCW = $clog2(NUM_CHUNKS + 1);
  localparam int CW  = (NCW > 5) ? NCW : 5;
  localparam int OW  = $clog2(CHUNK_BYTES + 1);
  localparam int PSW = (OW > SZW) ? OW : SZW;
  localparam int TW  = $clog2(SPLIT_DEPTH + 1);
  localparam int SIW = $clog2(SPLIT_DEPTH);
  localparam longint unsigned STORE_DEPTH = 64'(NUM_CHUNKS) * 64'(CHUNK_BYTES);
  localparam int SAW = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [OFW-1:0] ofs;
    logic [PSW-1:0] size;
  } piece_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_BIN,
    S_A_LINK,
    S_A_TAIL,
    S_A_OPEN,
    S_F_PIECE,
    S_F_BIN,
    S_F_NEXT,
    S_RESP
  } state_e;

  function automatic logic [SAW-1:0] store_idx(logic [CW-1:0] ch, logic [OFW-1:0] o);
    return SAW'(64'(ch) * 64'(CHUNK_BYTES) + 64'(o));
  endfunction

  function automatic logic store_ok(logic [CW-1:0] ch, logic [OFW-1:0] o);
    return (32'(ch) < NUM_CHUNKS) && (32'(o) < CHUNK_BYTES);
  endfunction

  function automatic logic [HW-1:0] make_handle(logic [CW-1:0] ch, logic [OFW-1:0] o);
    return HW'({ch, 16'h0000}) | HW'(o);
  endfunction

  state_e         state_q, state_d;
  logic           have_q, have_d;
  logic [NCW-1:0] tail_chunk_q, tail_chunk_d;
  logic [OW-1:0]  tail_off_q, tail_off_d;
  logic [MLW-1:0] min_lo_q;
  logic [TW-1:0]  top_q, top_d;
  logic           ret_alloc_q, ret_alloc_d;
  logic           rsp_vld_q, rsp_vld_d;

  logic [SZW-1:0] size_q, size_d;
  logic [HW-1:0]  hnd_q, hnd_d;
  logic [CW-1:0]  fchunk_q, fchunk_d;
  piece_t         cur_q, cur_d;
  piece_t         stack_q [SPLIT_DEPTH];
  piece_t         stack_d [SPLIT_DEPTH];
  logic [HW-1:0]  res_grant_q, res_grant_d;
  status_e        res_status_q, res_status_d;
  logic           res_bin_q, res_bin_d;
  logic [HW-1:0]  rsp_grant_q, rsp_grant_d;
  status_e        rsp_status_q, rsp_status_d;
  logic           rsp_bin_q, rsp_bin_d;

  bin_req_t       bin_req;
  logic [HW-1:0]  bin_rdata;
  logic           link_en, link_we;
  logic [SAW-1:0] link_addr;
  logic [HW-1:0]  link_wdata, link_rdata;

  logic           accept;
  logic [OW-1:0]  remain;
  logic           need_new, oversize, no_chunk, do_left;
  logic [NCW-1:0] next_chunk;
  logic [OW-1:0]  start_off;
  logic [CW-1:0]  tail_ch_w, pop_ch;
  logic [OFW-1:0] tail_o_w, pop_o;
  logic [HW-1:0]  tail_handle;
  logic [PSW-1:0] pa, pb, pc, pb2;
  logic [33:0]    div_prod;
  logic [TW-1:0]  top_p1, top_m1;

  scba_bin_mem u_bin_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bin_req),
    .rdata_o (bin_rdata)
  );

  scba_link_mem #(
    .AW    (SAW),
    .DEPTH (STORE_DEPTH),
    .DW    (HW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .en_i    (link_en),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // tail chunk bookkeeping
  assign remain     = (have_q && (32'(tail_off_q) < CHUNK_BYTES)) ?
                      OW'(32'(CHUNK_BYTES) - 32'(tail_off_q)) : '0;
  assign need_new   = !have_q || (32'(remain) < 32'(size_q));
  assign next_chunk = have_q ? tail_chunk_q + NCW'(1) : '0;
  assign start_off  = have_q ? '0 : OW'(1);
  assign oversize   = (32'(start_off) + 32'(size_q)) > 32'(CHUNK_BYTES);
  assign no_chunk   = 32'(next_chunk) >= NUM_CHUNKS;
  assign do_left    = have_q && (remain != '0) && (32'(remain) >= 32'(min_lo_q));
  assign tail_ch_w  = CW'(tail_chunk_q);
  assign tail_o_w   = OFW'(tail_off_q);
  assign tail_handle = make_handle(tail_ch_w, tail_o_w);

  assign pop_ch = CW'(bin_rdata[HW-1:16]);
  assign pop_o  = OFW'(bin_rdata[15:0]);

  // split of the current piece: a = s/2, b = (s-a) - c, c = (s-a)/3
  assign pa       = cur_q.size >> 1;
  assign pb       = cur_q.size - pa;
  assign div_prod = 34'(pb) * 34'(DIV3_MUL);
  assign pc       = PSW'(div_prod >> DIV3_SHIFT);
  assign pb2      = pb - pc;

  assign top_p1 = top_q + TW'(1);
  assign top_m1 = top_q - TW'(1);

  always_comb begin
    state_d      = state_q;
    have_d       = have_q;
    tail_chunk_d = tail_chunk_q;
    tail_off_d   = tail_off_q;
    top_d        = top_q;
    ret_alloc_d  = ret_alloc_q;
    size_d       = size_q;
    hnd_d        = hnd_q;
    fchunk_d     = fchunk_q;
    cur_d        = cur_q;
    stack_d      = stack_q;
    res_grant_d  = res_grant_q;
    res_status_d = res_status_q;
    res_bin_d    = res_bin_q;
    rsp_grant_d  = rsp_grant_q;
    rsp_status_d = rsp_status_q;
    rsp_bin_d    = rsp_bin_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    bin_req      = '0;
    link_en      = 1'b0;
    link_we      = 1'b0;
    link_addr    = '0;
    link_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          size_d       = req_i.size;
          res_grant_d  = '0;
          res_status_d = ST_OK;
          res_bin_d    = 1'b0;
          unique case (cmd_e'(req_i.command))
            CMD_ALLOC: begin
              if (32'(req_i.size) < NBINS) begin
                bin_req.en   = 1'b1;
                bin_req.addr = req_i.size[BIN_AW-1:0];
                state_d      = S_A_BIN;
              end else begin
                state_d = S_A_TAIL;
              end
            end
            CMD_FREE: begin
              fchunk_d    = CW'(req_i.block_handle[HW-1:16]);
              cur_d.ofs   = OFW'(req_i.block_handle[15:0]);
              cur_d.size  = PSW'(req_i.size);
              top_d       = '0;
              ret_alloc_d = 1'b0;
              state_d     = S_F_PIECE;
            end
            CMD_CLEAR: begin
              bin_req.clr  = 1'b1;
              have_d       = 1'b0;
              tail_chunk_d = '0;
              tail_off_d   = OW'(CHUNK_BYTES);
              state_d      = S_RESP;
            end
            CMD_NOP: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_A_BIN: begin
        if (bin_rdata != '0) begin
          hnd_d = bin_rdata;
          if (store_ok(pop_ch, pop_o)) begin
            link_en   = 1'b1;
            link_addr = store_idx(pop_ch, pop_o);
            state_d   = S_A_LINK;
          end else begin
            // head outside the store: the bin simply empties
            bin_req.en    = 1'b1;
            bin_req.we    = 1'b1;
            bin_req.addr  = size_q[BIN_AW-1:0];
            bin_req.wdata = '0;
            res_grant_d   = bin_rdata;
            res_bin_d     = 1'b1;
            state_d       = S_RESP;
          end
        end else begin
          state_d = S_A_TAIL;
        end
      end

      S_A_LINK: begin
        bin_req.en    = 1'b1;
        bin_req.we    = 1'b1;
        bin_req.addr  = size_q[BIN_AW-1:0];
        bin_req.wdata = link_rdata;
        link_en       = 1'b1;
        link_we       = 1'b1;
        link_addr     = store_idx(CW'(hnd_q[HW-1:16]), OFW'(hnd_q[15:0]));
        link_wdata    = hnd_q;
        res_grant_d   = hnd_q;
        res_bin_d     = 1'b1;
        state_d       = S_RESP;
      end

      S_A_TAIL: begin
        if (!need_new) begin
          if (store_ok(tail_ch_w, tail_o_w)) begin
            link_en    = 1'b1;
            link_we    = 1'b1;
            link_addr  = store_idx(tail_ch_w, tail_o_w);
            link_wdata = tail_handle;
          end
          tail_off_d  = OW'(32'(tail_off_q) + 32'(size_q));
          res_grant_d = tail_handle;
          state_d     = S_RESP;
        end else if (oversize) begin
          res_status_d = ST_OVERSIZE;
          state_d      = S_RESP;
        end else if (no_chunk) begin
          res_status_d = ST_NO_CHUNK;
          state_d      = S_RESP;
        end else if (do_left) begin
          // give the chunk remainder back, then open the next chunk
          fchunk_d    = tail_ch_w;
          cur_d.ofs   = tail_o_w;
          cur_d.size  = PSW'(remain);
          top_d       = '0;
          ret_alloc_d = 1'b1;
          state_d     = S_F_PIECE;
        end else begin
          have_d       = 1'b1;
          tail_chunk_d = next_chunk;
          tail_off_d   = start_off;
        end
      end

      S_A_OPEN: begin
        have_d       = 1'b1;
        tail_chunk_d = next_chunk;
        tail_off_d   = start_off;
        state_d      = S_A_TAIL;
      end

      S_F_PIECE: begin
        if (32'(cur_q.size) < NBINS) begin
          if (store_ok(fchunk_q, cur_q.ofs)) begin
            bin_req.en   = 1'b1;
            bin_req.addr = cur_q.size[BIN_AW-1:0];
            state_d      = S_F_BIN;
          end else begin
            state_d = S_F_NEXT;
          end
        end else if ((32'(top_q) + 32'd3) > SPLIT_DEPTH) begin
          state_d = S_F_NEXT;
        end else begin
          // push c and b, keep a as the next piece to walk
          stack_d[top_q[SIW-1:0]].ofs   = cur_q.ofs + OFW'(pa) + OFW'(pb2);
          stack_d[top_q[SIW-1:0]].size  = pc;
          stack_d[top_p1[SIW-1:0]].ofs  = cur_q.ofs + OFW'(pa);
          stack_d[top_p1[SIW-1:0]].size = pb2;
          cur_d.size = pa;
          top_d      = top_q + TW'(2);
        end
      end

      S_F_BIN: begin
        bin_req.en    = 1'b1;
        bin_req.we    = 1'b1;
        bin_req.addr  = cur_q.size[BIN_AW-1:0];
        bin_req.wdata = make_handle(fchunk_q, cur_q.ofs);
        link_en       = 1'b1;
        link_we       = 1'b1;
        link_addr     = store_idx(fchunk_q, cur_q.ofs);
        link_wdata    = bin_rdata;
        state_d       = S_F_NEXT;
      end

      S_F_NEXT: begin
        if (top_q == '0) begin
          state_d = ret_alloc_q ? S_A_OPEN : S_RESP;
        end else begin
          cur_d   = stack_q[top_m1[SIW-1:0]];
          top_d   = top_m1;
          state_d = S_F_PIECE;
        end
      end

      S_RESP: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d    = 1'b1;
          rsp_grant_d  = res_grant_q;
          rsp_status_d = res_status_q;
          rsp_bin_d    = res_bin_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_q       <= 1'b0;
      tail_chunk_q <= '0;
      tail_off_q   <= OW'(CHUNK_BYTES);
      min_lo_q     <= MLW'(MIN_LO_RST);
      top_q        <= '0;
      ret_alloc_q  <= 1'b0;
      rsp_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      have_q       <= have_d;
      tail_chunk_q <= tail_chunk_d;
      tail_off_q   <= tail_off_d;
      top_q        <= top_d;
      ret_alloc_q  <= ret_alloc_d;
      rsp_vld_q    <= rsp_vld_d;
      if (cfg_we_i) begin
        min_lo_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    hnd_q        <= hnd_d;
    fchunk_q     <= fchunk_d;
    cur_q        <= cur_d;
    stack_q      <= stack_d;
    res_grant_q  <= res_grant_d;
    res_status_q <= res_status_d;
    res_bin_q    <= res_bin_d;
    rsp_grant_q  <= rsp_grant_d;
    rsp_status_q <= rsp_status_d;
    rsp_bin_q    <= rsp_bin_d;
  end

  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.granted_handle = rsp_grant_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.from_bin       = rsp_bin_q;

`ifndef SYNTHESIS
  a_bin_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_bin_q |-> rsp_status_q == ST_OK && rsp_grant_q != '0)
    else $error("bin pop result without handle or with error status");

  a_tail_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tail_off_q) <= CHUNK_BYTES)
    else $error("tail offset past chunk end");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= SPLIT_DEPTH)
    else $error("split stack overflow");

  a_clear_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.command == CMD_CLEAR |=> !have_q && state_q == S_RESP)
    else $error("clear did not drop the tail chunk");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && !rsp_vld_q |=> rsp_vld_q && state_q == S_IDLE)
    else $error("finished item not moved to output register");
`endif

endmodule
